[rtl/core/sps_pkg.sv]
// Shared definitions for the stepper phase sequencer: counter width, register
// indexes and the coil pattern tables for full-step and half-step drive.
// No dependencies.
package sps_pkg;

  // Width of the step and delay counters.
  localparam int COUNT_WIDTH = 16;

  // Width of the phase index; half-step drive uses all eight phases.
  localparam int PHASE_WIDTH = 3;

  // Configuration register indexes.
  localparam logic [1:0] REG_HALF_STEP = 2'd0;
  localparam logic [1:0] REG_ENABLE    = 2'd1;
  localparam logic [1:0] REG_HOLD      = 2'd2;

  // Phase masks for the two drive modes.
  localparam logic [PHASE_WIDTH-1:0] HALF_MASK = 3'd7;
  localparam logic [PHASE_WIDTH-1:0] FULL_MASK = 3'd3;

  typedef logic [COUNT_WIDTH-1:0] count_t;
  typedef logic [PHASE_WIDTH-1:0] phase_t;
  typedef logic [3:0]             coil_t;

  // Full-step table: two adjacent coils on at every phase.
  function automatic coil_t full_step_coils(input logic [1:0] phase);
    coil_t coils;
    unique case (phase)
      2'd0: coils = 4'h3;
      2'd1: coils = 4'h6;
      2'd2: coils = 4'hC;
      2'd3: coils = 4'h9;
      default: coils = 4'h0;
    endcase
    return coils;
  endfunction

  // Half-step table: alternates between one and two coils on.
  function automatic coil_t half_step_coils(input phase_t phase);
    coil_t coils;
    unique case (phase)
      3'd0: coils = 4'h1;
      3'd1: coils = 4'h3;
      3'd2: coils = 4'h2;
      3'd3: coils = 4'h6;
      3'd4: coils = 4'h4;
      3'd5: coils = 4'hC;
      3'd6: coils = 4'h8;
      3'd7: coils = 4'h9;
      default: coils = 4'h0;
    endcase
    return coils;
  endfunction

endpackage

[rtl/core/stepper_phase_sequencer_unit.sv]
// Top level of the stepper phase sequencer: move commands and millisecond
// ticks update the phase, position and counters in one pass.
// Depends on sps_pkg.
//
// Timing: the result for an input beat is presented in the cycle after it is accepted.
// Throughput: one beat per cycle; the phase, position and counter update is one
// register-to-register pass, and a beat is taken whenever the result register is
// empty or is being emptied in the same cycle.
// Reset (rst, synchronous): counters, phase, position and coils clear, the block is
// idle, half-step mode is off, the motor is enabled and hold is on.
module stepper_phase_sequencer_unit
  import sps_pkg::*;
(
  input  logic               clk,
  input  logic               rst,

  // Input channel.
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               action,
  input  logic               move_direction,
  input  logic [15:0]        step_count,
  input  logic [15:0]        delay_ticks,

  // Result channel.
  output logic               out_valid,
  input  logic               out_stall,
  output logic [3:0]         coil_pattern,
  output logic signed [31:0] motor_position,
  output logic               busy_res,
  output logic               stepped,

  // Configuration write channel.
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic               cfg_data
);

  // Configuration registers.
  logic half_step_mode;
  logic motor_enabled;
  logic hold_position;

  // Sequencer state.
  phase_t      phase_index;
  logic [31:0] step_position;
  count_t      steps_left;
  count_t      wait_left;
  count_t      delay_reload;
  logic        current_direction;
  logic        move_active;
  coil_t       coil_drive;

  // Next values.
  phase_t      phase_index_next;
  logic [31:0] step_position_next;
  count_t      steps_left_next;
  count_t      wait_left_next;
  count_t      delay_reload_next;
  logic        current_direction_next;
  logic        move_active_next;
  coil_t       coil_drive_next;
  logic        moved;

  // Decode helpers.
  logic   in_accept;
  count_t cmd_count;
  count_t cmd_delay;
  logic   start_ok;
  count_t wait_dec;
  logic   tick_slot;
  logic   take_slot;
  logic   slot_dir;
  count_t slot_reload;
  count_t slot_steps;
  phase_t phase_mask;
  phase_t phase_step;

  // The result register is freed whenever its beat leaves.
  assign in_stall  = out_valid && out_stall;
  assign in_accept = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  // The result fields read the state directly; it only changes on an accepted beat.
  assign coil_pattern   = coil_drive;
  assign motor_position = step_position;
  assign busy_res       = move_active;

  // Command fields keep their low counter bits.
  assign cmd_count = count_t'(step_count);
  assign cmd_delay = count_t'(delay_ticks);

  // A command starts only when idle, enabled and asking for at least one step.
  assign start_ok  = !move_active && motor_enabled && (cmd_count != '0);
  assign wait_dec  = (wait_left != '0) ? wait_left - count_t'(1) : '0;
  assign tick_slot = move_active && (wait_dec == '0) && (steps_left != '0);
  assign take_slot = action ? start_ok : tick_slot;

  // A starting command supplies direction, delay and count; a tick uses the stored ones.
  assign slot_dir    = action ? move_direction : current_direction;
  assign slot_reload = action ? cmd_delay : delay_reload;
  assign slot_steps  = action ? cmd_count : steps_left;

  // Phase advance modulo four or eight; backward is adding the mask.
  assign phase_mask = half_step_mode ? HALF_MASK : FULL_MASK;
  assign phase_step = (slot_dir ? (phase_index + phase_mask) : (phase_index + phase_t'(1)))
                      & phase_mask;

  // Next-state logic for one beat.
  always_comb begin
    phase_index_next       = phase_index;
    step_position_next     = step_position;
    steps_left_next        = steps_left;
    wait_left_next         = wait_left;
    delay_reload_next      = delay_reload;
    current_direction_next = current_direction;
    move_active_next       = move_active;
    coil_drive_next        = coil_drive;
    moved                  = 1'b0;

    if (action && start_ok) begin
      current_direction_next = move_direction;
      delay_reload_next      = cmd_delay;
    end else if (!action && move_active) begin
      wait_left_next = wait_dec;
      if (wait_dec == '0 && steps_left == '0) begin
        move_active_next = 1'b0;
      end
    end

    if (take_slot) begin
      // A step time: move only if enabled, but always count it and reload the wait.
      if (motor_enabled) begin
        phase_index_next   = phase_step;
        coil_drive_next    = half_step_mode ? half_step_coils(phase_step)
                                            : full_step_coils(phase_step[1:0]);
        step_position_next = slot_dir ? step_position - 32'd1 : step_position + 32'd1;
        moved              = 1'b1;
      end
      if (!hold_position) begin
        coil_drive_next = '0;
      end
      steps_left_next  = slot_steps - count_t'(1);
      wait_left_next   = slot_reload;
      move_active_next = !((steps_left_next == '0) && (slot_reload == '0));
    end
  end

  // State and result registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase_index       <= '0;
      step_position     <= '0;
      steps_left        <= '0;
      wait_left         <= '0;
      delay_reload      <= '0;
      current_direction <= 1'b0;
      move_active       <= 1'b0;
      coil_drive        <= '0;
      stepped           <= 1'b0;
      out_valid         <= 1'b0;
    end else begin
      if (in_accept) begin
        phase_index       <= phase_index_next;
        step_position     <= step_position_next;
        steps_left        <= steps_left_next;
        wait_left         <= wait_left_next;
        delay_reload      <= delay_reload_next;
        current_direction <= current_direction_next;
        move_active       <= move_active_next;
        coil_drive        <= coil_drive_next;
        stepped           <= moved;
        out_valid         <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Configuration registers, written one bit per beat.
  always_ff @(posedge clk) begin
    if (rst) begin
      half_step_mode <= 1'b0;
      motor_enabled  <= 1'b1;
      hold_position  <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_HALF_STEP: half_step_mode <= cfg_data;
        REG_ENABLE:    motor_enabled  <= cfg_data;
        REG_HOLD:      hold_position  <= cfg_data;
        default: ;
      endcase
    end
  end

  // An accepted command that may start always produces a stepping result.
  assert property (@(posedge clk) disable iff (rst)
    (in_accept && action && start_ok) |=> (out_valid && stepped))
    else $error("start command did not step");

  // With hold off, the coils are released after every step time.
  assert property (@(posedge clk) disable iff (rst)
    (in_accept && take_slot && !hold_position) |=> (coil_pattern == 4'h0))
    else $error("coils still driven with hold off");

  // An idle sequencer has no steps left to take.
  assert property (@(posedge clk) disable iff (rst)
    !move_active |-> (steps_left == '0))
    else $error("idle with steps remaining");

  // A result that did not step leaves the position where it was.
  assert property (@(posedge clk) disable iff (rst)
    (in_accept && !moved) |=> (step_position == $past(step_position)))
    else $error("position changed without a step");

endmodule

[sim/tb_stepper_phase_sequencer_unit.sv]
// Self-checking testbench for stepper_phase_sequencer_unit: directed and random move
// and tick beats, with a beat-level predictor of phase, position, coils and busy.
// Depends on sps_pkg and the RTL top level.
module tb_stepper_phase_sequencer_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import sps_pkg::*;

  localparam logic ACT_TICK = 1'b0;
  localparam logic ACT_MOVE = 1'b1;
  localparam logic DIR_CW   = 1'b0;
  localparam logic DIR_CCW  = 1'b1;

  localparam int HOLD_CYCLES    = 40;
  localparam int WATCHDOG_LIMIT = 2000;

  localparam coil_t FULL_COILS [4] = '{4'h3, 4'h6, 4'hC, 4'h9};
  localparam coil_t HALF_COILS [8] = '{4'h1, 4'h3, 4'h2, 4'h6, 4'h4, 4'hC, 4'h8, 4'h9};

  typedef struct packed {
    coil_t              coils;
    logic signed [31:0] position;
    logic               busy;
    logic               moved;
  } drive_state_t;

  logic               clk;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic               action = ACT_TICK;
  logic               move_direction = DIR_CW;
  logic [15:0]        step_count = '0;
  logic [15:0]        delay_ticks = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [3:0]         coil_pattern;
  logic signed [31:0] motor_position;
  logic               busy_res;
  logic               stepped;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [1:0]         cfg_index = REG_HALF_STEP;
  logic               cfg_data = 1'b0;

  // Predicted motor state and register copies.
  logic               cfg_half;
  logic               cfg_enable;
  logic               cfg_hold;
  phase_t             rotor_phase;
  logic signed [31:0] step_pos;
  count_t             steps_to_go;
  count_t             ticks_to_go;
  count_t             tick_reload;
  logic               spin_ccw;
  logic               moving;
  coil_t              coil_out;

  drive_state_t       expected_drive [$];
  drive_state_t       want;
  int                 fail_count = 0;
  int                 beats_done = 0;
  int                 idle_cycles = 0;
  bit                 gaps_on = 1'b0;
  bit                 stalls_on = 1'b0;
  bit                 hold_req = 1'b0;

  stepper_phase_sequencer_unit DUT (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .action         (action),
    .move_direction (move_direction),
    .step_count     (step_count),
    .delay_ticks    (delay_ticks),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .coil_pattern   (coil_pattern),
    .motor_position (motor_position),
    .busy_res       (busy_res),
    .stepped        (stepped),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // One step time: advance the phase when enabled, count the step and reload the wait.
  function automatic logic advance_motor();
    phase_t lim;
    phase_t nxt;
    logic   moved;
    moved = 1'b0;
    if (cfg_enable) begin
      lim = cfg_half ? HALF_MASK : FULL_MASK;
      nxt = (spin_ccw ? rotor_phase + lim : rotor_phase + 3'd1) & lim;
      coil_out = cfg_half ? HALF_COILS[nxt] : FULL_COILS[nxt[1:0]];
      rotor_phase = nxt;
      step_pos = spin_ccw ? step_pos - 1 : step_pos + 1;
      moved = 1'b1;
    end
    if (!cfg_hold) coil_out = '0;
    steps_to_go = steps_to_go - count_t'(1);
    ticks_to_go = tick_reload;
    if (steps_to_go == '0 && ticks_to_go == '0) moving = 1'b0;
    return moved;
  endfunction

  // Updates the predicted state for one accepted beat and queues its result.
  // Returns 1 when the beat took part in a move.
  function automatic logic predict_beat(input logic act, input logic dir,
                                        input count_t cnt, input count_t dly);
    logic         moved;
    logic         was_moving;
    drive_state_t row;
    moved = 1'b0;
    was_moving = moving;
    if (act == ACT_MOVE) begin
      if (!moving && cfg_enable && cnt != '0) begin
        spin_ccw = dir;
        tick_reload = dly;
        steps_to_go = cnt;
        moving = 1'b1;
        moved = advance_motor();
      end
    end else if (moving) begin
      if (ticks_to_go != '0) ticks_to_go = ticks_to_go - count_t'(1);
      if (ticks_to_go == '0) begin
        if (steps_to_go != '0) moved = advance_motor();
        else moving = 1'b0;
      end
    end
    row.coils    = coil_out;
    row.position = step_pos;
    row.busy     = moving;
    row.moved    = moved;
    expected_drive.push_back(row);
    return was_moving || moving;
  endfunction

  // Sends one beat, with an optional gap in front, and predicts it once accepted.
  task automatic send_beat(input logic act, input logic dir, input count_t cnt,
                           input count_t dly);
    if (gaps_on && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    action <= act;
    move_direction <= dir;
    step_count <= cnt;
    delay_ticks <= dly;
    do @(posedge clk); while (in_stall);
    beats_done += int'(predict_beat(act, dir, cnt, dly));
  endtask

  // A tick carries junk in the move fields; the block ignores it.
  task automatic send_tick();
    send_beat(ACT_TICK, 1'($urandom_range(0, 1)), count_t'($urandom), count_t'($urandom));
  endtask

  task automatic run_ticks(input int n);
    repeat (n) send_tick();
  endtask

  // Register write once every expected result is in.
  task automatic set_register(input logic [1:0] idx, input logic val);
    in_valid <= 1'b0;
    do @(posedge clk); while (expected_drive.size() != 0);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_HALF_STEP: cfg_half = val;
      REG_ENABLE:    cfg_enable = val;
      REG_HOLD:      cfg_hold = val;
      default: ;
    endcase
  endtask

  // Idle ticks, zero-step moves, zero delay and moves while busy.
  task automatic test_move_commands();
    send_beat(ACT_TICK, DIR_CW, '0, '0);
    send_beat(ACT_MOVE, DIR_CCW, 16'd0, 16'hFFFF);
    send_beat(ACT_MOVE, DIR_CW, 16'd1, 16'd0);
    send_beat(ACT_MOVE, DIR_CCW, 16'd3, 16'd0);
    run_ticks(2);
    send_beat(ACT_MOVE, DIR_CW, 16'd2, 16'd2);
    send_beat(ACT_MOVE, DIR_CCW, 16'hFFFF, 16'hFFFF);
    run_ticks(5);
  endtask

  // Half-step drive, then back to full step with the phase beyond the full range.
  task automatic test_drive_modes();
    set_register(REG_HALF_STEP, 1'b1);
    send_beat(ACT_MOVE, DIR_CW, 16'd5, 16'd0);
    run_ticks(4);
    set_register(REG_HALF_STEP, 1'b0);
    send_beat(ACT_MOVE, DIR_CCW, 16'd2, 16'd0);
    run_ticks(1);
  endtask

  // Coils released with hold off; skipped steps when disabled before or during a move.
  task automatic test_disable_and_hold();
    set_register(REG_HOLD, 1'b0);
    send_beat(ACT_MOVE, DIR_CCW, 16'd2, 16'd1);
    run_ticks(3);
    set_register(REG_HOLD, 1'b1);
    set_register(REG_ENABLE, 1'b0);
    send_beat(ACT_MOVE, DIR_CW, 16'hFFFF, 16'hFFFF);
    set_register(REG_ENABLE, 1'b1);
    send_beat(ACT_MOVE, DIR_CW, 16'd3, 16'd1);
    run_ticks(1);
    set_register(REG_ENABLE, 1'b0);
    set_register(REG_HOLD, 1'b0);
    run_ticks(4);
    set_register(REG_ENABLE, 1'b1);
    set_register(REG_HOLD, 1'b1);
  endtask

  // Mostly complete moves with random content, mixed with register changes and noise.
  task automatic test_random_moves(input int target);
    int     goal;
    int     pick;
    count_t cnt;
    count_t dly;
    goal = beats_done + target;
    while (beats_done < goal) begin
      pick = $urandom_range(0, 15);
      if (pick == 0) begin
        set_register(REG_HALF_STEP, 1'($urandom_range(0, 1)));
      end else if (pick == 1) begin
        set_register(REG_HOLD, 1'($urandom_range(0, 1)));
      end else if (pick == 2) begin
        set_register(REG_ENABLE, $urandom_range(0, 7) != 0);
      end else if (pick == 3) begin
        // Idle noise: a tick, or a move that cannot start.
        if ($urandom_range(0, 1) == 0) send_tick();
        else send_beat(ACT_MOVE, 1'($urandom_range(0, 1)),
                       cfg_enable ? count_t'(0) : count_t'($urandom), count_t'($urandom));
      end else begin
        pick = $urandom_range(0, 19);
        if (pick == 0) begin
          cnt = count_t'($urandom_range(20, 60));
          dly = '0;
        end else if (pick == 1) begin
          cnt = count_t'($urandom_range(1, 2));
          dly = count_t'($urandom_range(100, 300));
        end else begin
          cnt = count_t'($urandom_range(1, 8));
          dly = count_t'($urandom_range(0, 4));
        end
        send_beat(ACT_MOVE, 1'($urandom_range(0, 1)), cnt, dly);
        while (moving) begin
          pick = $urandom_range(0, 39);
          if (pick == 0) set_register(REG_ENABLE, !cfg_enable);
          else if (pick < 4) send_beat(ACT_MOVE, 1'($urandom_range(0, 1)),
                                       count_t'($urandom), count_t'($urandom));
          else send_tick();
        end
      end
    end
  endtask

  // Long receiver hold-off while ticks keep coming, so the input side stalls.
  task automatic test_back_pressure();
    set_register(REG_ENABLE, 1'b1);
    send_beat(ACT_MOVE, DIR_CW, 16'd48, 16'd0);
    hold_req = 1'b1;
    run_ticks(48);
  endtask

  task automatic finish_run();
    in_valid <= 1'b0;
    while (expected_drive.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  endtask

  // Result side: random stall bursts, or one long hold when requested.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_stall <= 1'b0;
        hold_req = 1'b0;
      end else if (stalls_on && $urandom_range(0, 4) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 4)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // Compare each result beat with the oldest expectation.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (expected_drive.size() == 0) begin
        $error("result beat with no expectation waiting");
        fail_count++;
      end else begin
        want = expected_drive.pop_front();
        if (coil_pattern !== want.coils) begin
          $error("coil_pattern: expected %h, got %h", want.coils, coil_pattern);
          fail_count++;
        end
        if (motor_position !== want.position) begin
          $error("motor_position: expected %0d, got %0d", want.position, motor_position);
          fail_count++;
        end
        if (busy_res !== want.busy) begin
          $error("busy_res: expected %b, got %b", want.busy, busy_res);
          fail_count++;
        end
        if (stepped !== want.moved) begin
          $error("stepped: expected %b, got %b", want.moved, stepped);
          fail_count++;
        end
      end
    end
  end

  // Watchdog on cycles with no beat moving on any channel.
  always @(posedge clk) begin
    if (!rst) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  initial begin
    cfg_half = 1'b0;
    cfg_enable = 1'b1;
    cfg_hold = 1'b1;
    rotor_phase = '0;
    step_pos = '0;
    steps_to_go = '0;
    ticks_to_go = '0;
    tick_reload = '0;
    spin_ccw = DIR_CW;
    moving = 1'b0;
    coil_out = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    test_move_commands();
    test_drive_modes();
    test_disable_and_hold();
    gaps_on = 1'b1;
    stalls_on = 1'b1;
    test_random_moves(650);
    test_back_pressure();
    test_random_moves(150);
    gaps_on = 1'b0;
    stalls_on = 1'b0;
    test_random_moves(150);
    finish_run();
  end

endmodule

[stepper_phase_sequencer_unit.f]
rtl/core/sps_pkg.sv
rtl/core/stepper_phase_sequencer_unit.sv
sim/tb_stepper_phase_sequencer_unit.sv
